// File: rtl/cpbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpbm_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int PAGE_W    = 32;
    localparam int SIU_W     = 7;
    localparam logic [SIU_W-1:0] SIU_RESET = 7'd64;

    typedef enum logic [2:0] {
        KIND_LOOKUP  = 3'd0,
        KIND_PRESENT = 3'd1,
        KIND_BATCH   = 3'd2,
        KIND_SLOTQ   = 3'd3,
        KIND_HIST    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PLACE,
        ST_HWR,
        ST_RD,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic place;
        logic hist_wr;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  batch_rej;
        logic  found;
        logic  scan_last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/cpbm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cpbm_ctrl import cpbm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    KIND_LOOKUP, KIND_PRESENT: state_next = ST_SCAN;
                    KIND_BATCH:   state_next = sts.batch_rej ? ST_DONE : ST_SCAN;
                    KIND_SLOTQ, KIND_HIST: state_next = ST_RD;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    if (sts.kind == KIND_PRESENT || (sts.kind == KIND_LOOKUP && sts.found))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_RD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cpbm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module cpbm_dpath import cpbm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIU_W-1:0]  cfg_wr_data,
    input  wire logic [2:0]        kind,
    input  wire logic [PAGE_W-1:0] page_id,
    input  wire logic [6:0]        index,
    input  wire logic              first_of_batch,
    input  wire logic [15:0]       batch_size,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_sts_t              sts,
    output logic                   done,
    output logic [5:0]             slot,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [PAGE_W-1:0]      page_out,
    output logic                   occupied,
    output logic [PAGE_W-1:0]      count,
    output logic                   rejected
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int NW = (PW > SIU_W) ? PW : SIU_W;

    // storage
    logic [PAGE_W-1:0] page_mem [SLOTS];
    logic [PAGE_W-1:0] hist_mem [SLOTS];
    logic [PAGE_W-1:0] page_rd_reg;
    logic [PAGE_W-1:0] hist_rd_reg;

    logic [SIU_W-1:0]  siu_reg;
    kind_t             kind_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [6:0]        idx_reg;
    logic              first_reg;
    logic [15:0]       bsize_reg;
    logic [AW-1:0]     s_reg;

    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  live_reg;
    logic [SLOTS-1:0]  hist_vld_reg;
    logic [AW-1:0]     fp_reg;
    logic [PW-1:0]     run_pos_reg;
    logic [PAGE_W-1:0] last_reg;

    logic [AW:0]       scan_cnt_reg;
    logic              found_reg;
    logic [AW-1:0]     h_reg;
    logic [PAGE_W-1:0] evict_page_reg;
    logic              evict_vld_reg;
    logic [PW-1:0]     pos_reg;

    logic              done_reg;
    logic [5:0]        slot_reg;
    logic              hit_reg;
    logic              evicted_valid_reg;
    logic [PAGE_W-1:0] evicted_page_reg;
    logic [PAGE_W-1:0] page_out_reg;
    logic              occupied_reg;
    logic [PAGE_W-1:0] count_reg;
    logic              rejected_reg;

    // combinational
    logic [NW-1:0]     n_eff;
    logic [AW-1:0]     s_now;
    logic [NW-1:0]     s_inc;
    logic [AW-1:0]     fp_next;
    logic [31:0]       idx_w;
    logic [31:0]       idxm1_w;
    logic [AW-1:0]     idx_addr;
    logic [AW-1:0]     idxm1_addr;
    logic [AW:0]       cnt_m1;
    logic [AW-1:0]     cmp_idx;
    logic              cmp_vld;
    logic              match;
    logic              found_next;
    logic              run_brk;
    logic [PW-1:0]     pos_now;
    logic [PW-1:0]     run_pos_next;
    logic [AW-1:0]     page_raddr;
    logic [AW-1:0]     hist_raddr;
    logic [PAGE_W-1:0] hist_old;
    logic [PAGE_W-1:0] hist_new;
    logic              batch_rej;

    logic [5:0]        res_slot;
    logic              res_hit;
    logic              res_evv;
    logic [PAGE_W-1:0] res_evp;
    logic [PAGE_W-1:0] res_page;
    logic              res_occ;
    logic [PAGE_W-1:0] res_count;
    logic              res_rej;
    logic [31:0]       slot_w;

    // slots_in_use clamped to 1..SLOTS
    always_comb
    begin
        if (siu_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(siu_reg) > NW'(SLOTS))
        begin
            n_eff = NW'(SLOTS);
        end
        else
        begin
            n_eff = NW'(siu_reg);
        end
    end

    assign s_now   = (NW'(fp_reg) >= n_eff) ? '0 : fp_reg;
    assign s_inc   = NW'(s_reg) + NW'(1);
    assign fp_next = (s_inc >= n_eff) ? '0 : s_inc[AW-1:0];

    assign idx_w      = 32'(idx_reg);
    assign idxm1_w    = 32'(idx_reg - 7'd1);
    assign idx_addr   = idx_w[AW-1:0];
    assign idxm1_addr = idxm1_w[AW-1:0];

    // scan: read issued for scan_cnt, compared in the cycle after
    assign cnt_m1     = scan_cnt_reg - (AW + 1)'(1);
    assign cmp_idx    = cnt_m1[AW-1:0];
    assign cmp_vld    = cmd.scan && (scan_cnt_reg != '0);
    assign match      = cmp_vld && live_reg[cmp_idx] && (page_rd_reg == page_reg);
    assign found_next = found_reg | match;

    assign run_brk = first_reg || (run_pos_reg == '0) || (page_reg != last_reg + 32'd1);
    assign pos_now = (kind_reg == KIND_BATCH && !run_brk) ? run_pos_reg : '0;
    assign run_pos_next = (kind_reg == KIND_BATCH)
                        ? ((pos_now == PW'(SLOTS)) ? pos_now : pos_now + PW'(1))
                        : '0;

    assign page_raddr = cmd.scan ? scan_cnt_reg[AW-1:0] : idx_addr;
    assign hist_raddr = (kind_reg == KIND_HIST) ? idxm1_addr : pos_now[AW-1:0];

    assign hist_old = hist_vld_reg[pos_reg[AW-1:0]] ? hist_rd_reg : '0;
    assign hist_new = (hist_old == '1) ? hist_old : hist_old + 32'd1;

    assign batch_rej = (bsize_reg == '0) || (32'(bsize_reg) > 32'(n_eff));

    assign sts.kind      = kind_reg;
    assign sts.batch_rej = batch_rej;
    assign sts.found     = found_next;
    assign sts.scan_last = (scan_cnt_reg == (AW + 1)'(SLOTS));

    // result of the finished item
    always_comb
    begin
        slot_w    = '0;
        res_hit   = 1'b0;
        res_evv   = 1'b0;
        res_evp   = '0;
        res_page  = '0;
        res_occ   = 1'b0;
        res_count = '0;
        res_rej   = 1'b0;
        case (kind_reg)
            KIND_LOOKUP:
            begin
                if (found_reg)
                begin
                    slot_w  = 32'(h_reg);
                    res_hit = 1'b1;
                end
                else
                begin
                    slot_w  = 32'(s_reg);
                    res_evv = evict_vld_reg;
                    res_evp = evict_vld_reg ? evict_page_reg : '0;
                end
            end
            KIND_PRESENT:
            begin
                if (found_reg)
                begin
                    slot_w  = 32'(h_reg);
                    res_hit = 1'b1;
                end
            end
            KIND_BATCH:
            begin
                if (batch_rej)
                begin
                    res_rej = 1'b1;
                end
                else
                begin
                    slot_w  = 32'(s_reg);
                    res_evv = evict_vld_reg;
                    res_evp = evict_vld_reg ? evict_page_reg : '0;
                end
            end
            KIND_SLOTQ:
            begin
                if (NW'(idx_reg) >= n_eff)
                begin
                    res_rej = 1'b1;
                end
                else if (valid_reg[idx_addr])
                begin
                    res_page = page_rd_reg;
                    res_occ  = 1'b1;
                end
            end
            KIND_HIST:
            begin
                if (NW'(idx_reg) > n_eff)
                begin
                    res_rej = 1'b1;
                end
                else if (idx_reg != '0 && hist_vld_reg[idxm1_addr])
                begin
                    res_count = hist_rd_reg;
                end
            end
            default:
            begin
                res_rej = 1'b0;
            end
        endcase
        res_slot = slot_w[5:0];
    end

    // memories
    always_ff @(posedge clk)
    begin
        page_rd_reg <= page_mem[page_raddr];
        if (cmd.place)
        begin
            page_mem[s_reg] <= page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[hist_raddr];
        if (cmd.hist_wr && pos_reg < PW'(SLOTS))
        begin
            hist_mem[pos_reg[AW-1:0]] <= hist_new;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg      <= SIU_RESET;
            valid_reg    <= '0;
            live_reg     <= '0;
            hist_vld_reg <= '0;
            fp_reg       <= '0;
            run_pos_reg  <= '0;
            last_reg     <= '0;
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_wr_en)
            begin
                siu_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_cnt_reg <= scan_cnt_reg + (AW + 1)'(1);
                found_reg    <= found_next;
            end
            if (cmd.place)
            begin
                if (found_reg && h_reg != s_reg)
                begin
                    live_reg[h_reg] <= 1'b0;
                end
                valid_reg[s_reg] <= 1'b1;
                live_reg[s_reg]  <= 1'b1;
                fp_reg           <= fp_next;
                run_pos_reg      <= run_pos_next;
                last_reg         <= page_reg;
            end
            if (cmd.hist_wr && pos_reg < PW'(SLOTS))
            begin
                hist_vld_reg[pos_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    // item payload and scan results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(kind);
            page_reg  <= page_id;
            idx_reg   <= index;
            first_reg <= first_of_batch;
            bsize_reg <= batch_size;
            s_reg     <= s_now;
        end
        if (match && !found_reg)
        begin
            h_reg <= cmp_idx;
        end
        if (cmp_vld && cmp_idx == s_reg)
        begin
            evict_page_reg <= page_rd_reg;
        end
        if (cmd.place)
        begin
            evict_vld_reg <= valid_reg[s_reg] && live_reg[s_reg];
            pos_reg       <= pos_now;
        end
        if (cmd.finish)
        begin
            slot_reg          <= res_slot;
            hit_reg           <= res_hit;
            evicted_valid_reg <= res_evv;
            evicted_page_reg  <= res_evp;
            page_out_reg      <= res_page;
            occupied_reg      <= res_occ;
            count_reg         <= res_count;
            rejected_reg      <= res_rej;
        end
    end

    assign done          = done_reg;
    assign slot          = slot_reg;
    assign hit           = hit_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign page_out      = page_out_reg;
    assign occupied      = occupied_reg;
    assign count         = count_reg;
    assign rejected      = rejected_reg;

endmodule

`default_nettype wire

// File: rtl/circular_page_buffer_map_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Page-to-slot map with circular fill. One beat in, one beat out: a beat is
// taken when start is high and busy low, and its result appears on the result
// ports for exactly one cycle, marked by done. The receiver cannot stall, so
// it must take every result in the cycle it is shown. Lookups, presence checks
// and batch pages scan the page table from its synchronous RAM one slot a
// cycle. A lookup hit or a presence check runs decode, scan, result; a lookup
// miss or a batch page also places the page and updates the histogram after
// the scan. Slot queries and histogram reads run decode, read, result; a
// rejected batch or an unknown kind runs decode, result. The scan of the
// single-ported page table is the longest step. slots_in_use is written
// through cfg_wr_en / cfg_wr_data, by the user only while busy is low; the
// block does not enforce this. No clearing pass is needed after reset.

module circular_page_buffer_map_top import cpbm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [SIU_W-1:0]  cfg_wr_data,
    // command beat
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        kind,
    input  wire logic [PAGE_W-1:0] page_id,
    input  wire logic [6:0]        index,
    input  wire logic              first_of_batch,
    input  wire logic [15:0]       batch_size,
    // result beat
    output logic                   done,
    output logic [5:0]             slot,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [PAGE_W-1:0]      page_out,
    output logic                   occupied,
    output logic [PAGE_W-1:0]      count,
    output logic                   rejected
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: decode, scan, place, histogram update, read, result
    cpbm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // page table, valid/live flags, fill pointer, run histogram
    cpbm_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .kind           (kind),
        .page_id        (page_id),
        .index          (index),
        .first_of_batch (first_of_batch),
        .batch_size     (batch_size),
        .cmd            (cmd),
        .sts            (sts),
        .done           (done),
        .slot           (slot),
        .hit            (hit),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .page_out       (page_out),
        .occupied       (occupied),
        .count          (count),
        .rejected       (rejected)
    );

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Bench for the circular page buffer map.
// Every accepted command beat is run through a local model of the slot table
// and the run histogram, and the result it predicts (or a typed row's own expectation) is queued. Each result beat
// (done) is checked against the head of that queue.
module testbench;
    import cpbm_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int ITEMS       = 1000;
    localparam int PHASE_ITEMS = 85;
    localparam int CYCLE_LIMIT = 600_000;

    // kinds the block answers with an all-zero result
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    typedef struct packed {
        logic [5:0]  slot;
        logic        hit;
        logic        evicted_valid;
        logic [31:0] evicted_page;
        logic [31:0] page_out;
        logic        occupied;
        logic [31:0] count;
        logic        rejected;
    } page_result_t;

    localparam page_result_t RES_NONE = '0;
    localparam page_result_t RES_REJ  =
        '{6'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1};
    // page found at slot 0
    localparam page_result_t RES_HIT0 =
        '{6'd0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};
    // slot 0 still holds the top page id, though its home has moved
    localparam page_result_t RES_Q0   =
        '{6'd0, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0};

    // one row of the opening sequence; typed rows carry their own expectation
    typedef struct packed {
        logic [2:0]   k;
        logic [31:0]  page;
        logic [6:0]   idx;
        logic         fob;
        logic [15:0]  bsz;
        logic         typed;
        page_result_t res;
    } opening_row_t;

    localparam int N_OPENING = 26;
    localparam opening_row_t OPENING [N_OPENING] = '{
        // empty table straight out of reset
        '{KIND_SLOTQ,   32'h0000_0000, 7'd0,   1'b0, 16'd0,    1'b1, RES_NONE},
        '{KIND_HIST,    32'h0000_0000, 7'd0,   1'b0, 16'd0,    1'b1, RES_NONE},
        '{KIND_PRESENT, 32'h0000_0000, 7'd127, 1'b1, 16'hFFFF, 1'b1, RES_NONE},
        // miss goes to slot 0 with nothing to evict, then hits there
        '{KIND_LOOKUP,  32'hFFFF_FFFF, 7'd0,   1'b0, 16'd0,    1'b1, RES_NONE},
        '{KIND_LOOKUP,  32'hFFFF_FFFF, 7'd0,   1'b0, 16'd0,    1'b1, RES_HIT0},
        '{KIND_PRESENT, 32'hFFFF_FFFF, 7'd0,   1'b0, 16'd0,    1'b1, RES_HIT0},
        // empty batch, largest batch, one more than the slots in use
        '{KIND_BATCH,   32'h0000_0001, 7'd0,   1'b1, 16'd0,    1'b1, RES_REJ},
        '{KIND_BATCH,   32'hAAAA_5555, 7'd64,  1'b1, 16'hFFFF, 1'b1, RES_REJ},
        '{KIND_BATCH,   32'h5555_AAAA, 7'd0,   1'b1, 16'd65,   1'b1, RES_REJ},
        // run across the id wrap; the second page is loaded twice
        '{KIND_BATCH,   32'hFFFF_FFFE, 7'd0,   1'b1, 16'd3,    1'b0, RES_NONE},
        '{KIND_BATCH,   32'hFFFF_FFFF, 7'd0,   1'b0, 16'd3,    1'b0, RES_NONE},
        '{KIND_BATCH,   32'h0000_0000, 7'd0,   1'b0, 16'd3,    1'b0, RES_NONE},
        '{KIND_SLOTQ,   32'h0000_0000, 7'd0,   1'b0, 16'd0,    1'b1, RES_Q0},
        '{KIND_PRESENT, 32'hFFFF_FFFF, 7'd0,   1'b0, 16'd0,    1'b0, RES_NONE},
        '{KIND_HIST,    32'h0000_0000, 7'd1,   1'b0, 16'd0,    1'b0, RES_NONE},
        '{KIND_HIST,    32'h0000_0000, 7'd3,   1'b0, 16'd0,    1'b0, RES_NONE},
        // last histogram position is legal, beyond it is refused
        '{KIND_HIST,    32'h0000_0000, 7'd64,  1'b0, 16'd0,    1'b0, RES_NONE},
        '{KIND_HIST,    32'h0000_0000, 7'd65,  1'b0, 16'd0,    1'b1, RES_REJ},
        '{KIND_HIST,    32'h0000_0000, 7'd127, 1'b0, 16'd0,    1'b1, RES_REJ},
        '{KIND_SLOTQ,   32'h0000_0000, 7'd63,  1'b0, 16'd0,    1'b1, RES_NONE},
        '{KIND_SLOTQ,   32'h0000_0000, 7'd64,  1'b0, 16'd0,    1'b1, RES_REJ},
        '{KIND_SLOTQ,   32'h0000_0000, 7'd127, 1'b0, 16'd0,    1'b1, RES_REJ},
        // unknown kinds with every field set
        '{KIND_RSVD5,   32'hFFFF_FFFF, 7'd127, 1'b1, 16'hFFFF, 1'b1, RES_NONE},
        '{KIND_RSVD7,   32'hFFFF_FFFF, 7'd127, 1'b1, 16'hFFFF, 1'b1, RES_NONE},
        // miss ends the run
        '{KIND_LOOKUP,  32'h1234_5678, 7'd0,   1'b0, 16'd0,    1'b0, RES_NONE},
        '{KIND_RSVD6,   32'h0F0F_F0F0, 7'd85,  1'b0, 16'h5A5A, 1'b1, RES_NONE}
    };

    // slots_in_use plan; phases 3 and 7 draw a random mid value instead
    localparam logic [6:0] CFG_PLAN [8] =
        '{7'd1, 7'd127, 7'd0, 7'd9, 7'd65, 7'd64, 7'd2, 7'd8};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [SIU_W-1:0] cfg_wr_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] kind = '0;
    logic [PAGE_W-1:0] page_id = '0;
    logic [6:0] index = '0;
    logic first_of_batch = 1'b0;
    logic [15:0] batch_size = '0;
    logic done;
    logic [5:0] slot;
    logic hit;
    logic evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [PAGE_W-1:0] page_out;
    logic occupied;
    logic [PAGE_W-1:0] count;
    logic rejected;

    circular_page_buffer_map_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .page_id        (page_id),
        .index          (index),
        .first_of_batch (first_of_batch),
        .batch_size     (batch_size),
        .done           (done),
        .slot           (slot),
        .hit            (hit),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .page_out       (page_out),
        .occupied       (occupied),
        .count          (count),
        .rejected       (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- local copy of the slot table and the run histogram ----
    logic [31:0] pg_tab   [SLOTS];
    bit          pg_valid [SLOTS];
    bit          pg_home  [SLOTS];   // slot is the current home of its page
    int          fill_ptr;
    logic [31:0] run_hist [SLOTS];
    int          run_len;            // pages in the current run, 0 = none
    logic [31:0] prev_load;
    logic [6:0]  siu_reg;

    page_result_t pending_results [$];

    int  n_items;      // beats that did real work
    int  n_beats;
    int  n_checked;
    int  n_err;
    int  n_cfg;
    int  n_long;
    int  cycles;
    bit  no_idle;      // stretch of back-to-back beats

    // register out of range is clamped to 1..SLOTS
    function automatic int active_slots();
        if (siu_reg == 0)
            return 1;
        if (siu_reg > SLOTS)
            return SLOTS;
        return siu_reg;
    endfunction

    function automatic int home_of(input logic [31:0] p);
        for (int i = 0; i < SLOTS; i++)
            if (pg_home[i] && pg_tab[i] == p)
                return i;
        return -1;
    endfunction

    function automatic void hist_bump(input int pos);
        if (pos < SLOTS && run_hist[pos] != 32'hFFFF_FFFF)
            run_hist[pos] = run_hist[pos] + 32'd1;
    endfunction

    // put a page at the fill pointer; an old page only counts as evicted
    // if the slot is still its home
    function automatic logic [5:0] place_page(input logic [31:0] p,
                                              output logic ev_v,
                                              output logic [31:0] ev_p);
        int n;
        int s;
        n = active_slots();
        s = (fill_ptr >= n) ? 0 : fill_ptr;
        ev_v = 1'b0;
        ev_p = '0;
        if (pg_valid[s] && pg_home[s])
        begin
            ev_v = 1'b1;
            ev_p = pg_tab[s];
        end
        for (int i = 0; i < SLOTS; i++)
            if (i != s && pg_home[i] && pg_tab[i] == p)
                pg_home[i] = 1'b0;
        pg_tab[s]   = p;
        pg_valid[s] = 1'b1;
        pg_home[s]  = 1'b1;
        fill_ptr    = (s + 1 >= n) ? 0 : s + 1;
        return s[5:0];
    endfunction

    function automatic page_result_t map_predict(input logic [2:0] k,
                                                 input logic [31:0] p,
                                                 input logic [6:0] idx,
                                                 input logic fob,
                                                 input logic [15:0] bsz);
        page_result_t r;
        int n;
        int h;
        int pos;
        logic ev_v;
        logic [31:0] ev_p;
        r = '0;
        n = active_slots();
        case (k)
            KIND_LOOKUP:
            begin
                h = home_of(p);
                if (h >= 0)
                begin
                    r.slot = h[5:0];
                    r.hit  = 1'b1;
                end
                else
                begin
                    r.slot = place_page(p, ev_v, ev_p);
                    r.evicted_valid = ev_v;
                    r.evicted_page  = ev_p;
                    hist_bump(0);
                    run_len   = 0;
                    prev_load = p;
                end
            end
            KIND_PRESENT:
            begin
                h = home_of(p);
                if (h >= 0)
                begin
                    r.slot = h[5:0];
                    r.hit  = 1'b1;
                end
            end
            KIND_BATCH:
            begin
                if (bsz == 0 || bsz > n)
                    r.rejected = 1'b1;
                else
                begin
                    if (fob || run_len == 0 || p != prev_load + 32'd1)
                        pos = 0;
                    else
                        pos = run_len;
                    r.slot = place_page(p, ev_v, ev_p);
                    r.evicted_valid = ev_v;
                    r.evicted_page  = ev_p;
                    hist_bump(pos);
                    run_len   = (pos + 1 > SLOTS) ? SLOTS : pos + 1;
                    prev_load = p;
                end
            end
            KIND_SLOTQ:
            begin
                if (idx >= n)
                    r.rejected = 1'b1;
                else if (pg_valid[idx])
                begin
                    r.page_out = pg_tab[idx];
                    r.occupied = 1'b1;
                end
            end
            KIND_HIST:
            begin
                if (idx > n)
                    r.rejected = 1'b1;
                else if (idx > 0)
                    r.count = run_hist[idx - 1];
            end
            default: ;
        endcase
        return r;
    endfunction

    // an old page id now and then, so lookups hit and batches reload pages
    function automatic logic [31:0] pick_page();
        int s;
        s = $urandom_range(0, SLOTS - 1);
        if (pg_valid[s] && $urandom_range(0, 3) != 0)
            return pg_tab[s];
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // Present one command beat and wait for it to be taken. start is left
    // high after the beat so a zero gap gives back-to-back beats; a gap
    // lowers it first.
    task automatic issue_cmd(input logic [2:0] k, input logic [31:0] p,
                             input logic [6:0] idx, input logic fob,
                             input logic [15:0] bsz, input logic typed,
                             input page_result_t typed_res);
        int gap;
        page_result_t pred;
        if ($urandom_range(0, 29) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= k;
        page_id        <= p;
        index          <= idx;
        first_of_batch <= fob;
        batch_size     <= bsz;
        do
            @(posedge clk);
        while (busy);
        pred = map_predict(k, p, idx, fob, bsz);
        pending_results.push_back(typed ? typed_res : pred);
        n_beats++;
        if (k <= KIND_HIST && !(k == KIND_BATCH && pred.rejected))
            n_items++;
    endtask

    // consecutive pages of one batch, with the odd break unless brk is 0
    task automatic load_run(input logic [31:0] base, input int len,
                            input logic [15:0] bsz, input logic fresh,
                            input int brk);
        logic [31:0] p;
        p = base;
        for (int i = 0; i < len; i++)
        begin
            if (i > 0)
                p = (brk > 0 && $urandom_range(1, brk) == 1) ? $urandom : p + 32'd1;
            issue_cmd(KIND_BATCH, p, $urandom_range(0, 127), fresh && i == 0, bsz,
                      1'b0, RES_NONE);
        end
    endtask

    // register write only with the block idle and every result back
    task automatic set_slots_in_use(input logic [6:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        siu_reg = v;
        n_cfg++;
    endtask

    function automatic void note_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            n_err++;
        end
    endfunction

    // result beats: shown for one cycle, taken at the edge that ends it
    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && done)
        begin
            n_checked++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, got slot %h",
                         $time, slot);
                n_err++;
            end
            else
            begin
                want = pending_results.pop_front();
                note_field("slot",          want.slot,          slot);
                note_field("hit",           want.hit,           hit);
                note_field("evicted_valid", want.evicted_valid, evicted_valid);
                note_field("evicted_page",  want.evicted_page,  evicted_page);
                note_field("page_out",      want.page_out,      page_out);
                note_field("occupied",      want.occupied,      occupied);
                note_field("count",         want.count,         count);
                note_field("rejected",      want.rejected,      rejected);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding",
                     $time, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int n;
        int pick;
        int len;
        int phase;
        int next_cfg_at;
        int goal;
        logic [6:0] v;
        logic [31:0] base;

        for (int i = 0; i < SLOTS; i++)
        begin
            pg_tab[i]   = '0;
            pg_valid[i] = 1'b0;
            pg_home[i]  = 1'b0;
            run_hist[i] = '0;
        end
        fill_ptr  = 0;
        run_len   = 0;
        prev_load = '0;
        siu_reg   = SIU_RESET;
        n_items = 0;
        n_beats = 0;
        n_checked = 0;
        n_err = 0;
        n_cfg = 0;
        n_long = 0;
        cycles = 0;
        no_idle = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening sequence at the reset setting of 64 slots
        for (int r = 0; r < N_OPENING; r++)
            issue_cmd(OPENING[r].k, OPENING[r].page, OPENING[r].idx, OPENING[r].fob,
                      OPENING[r].bsz, OPENING[r].typed, OPENING[r].res);

        // random part, phased over register settings
        goal = n_items + ITEMS;
        phase = 0;
        next_cfg_at = n_items;
        while (n_items < goal)
        begin
            if (n_items >= next_cfg_at)
            begin
                v = (phase % 4 == 3) ? $urandom_range(3, 63) : CFG_PLAN[phase % 8];
                set_slots_in_use(v);
                phase++;
                next_cfg_at = n_items + PHASE_ITEMS;
            end
            n = active_slots();
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // well-formed batch, mostly short; sometimes it carries on the
                // previous run instead of opening a new one
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n)
                                                  : $urandom_range(1, (n < 6) ? n : 6);
                if ($urandom_range(0, 3) == 0)
                    load_run(prev_load + 32'd1, len, len, 1'b0, 12);
                else
                    load_run(pick_page(), len, len, $urandom_range(0, 7) != 0, 12);
            end
            else if (pick < 42 && n_long < 4)
            begin
                // run longer than the histogram, so the position saturates
                load_run($urandom, SLOTS + 6, $urandom_range(1, n), 1'b1, 0);
                n_long++;
            end
            else if (pick < 62)
                issue_cmd(KIND_LOOKUP, pick_page(), $urandom_range(0, 127),
                          $urandom_range(0, 1), $urandom, 1'b0, RES_NONE);
            else if (pick < 72)
                issue_cmd(KIND_PRESENT, pick_page(), $urandom_range(0, 127),
                          $urandom_range(0, 1), $urandom, 1'b0, RES_NONE);
            else if (pick < 82)
                issue_cmd(KIND_SLOTQ, $urandom,
                          ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                      : $urandom_range(0, 127),
                          $urandom_range(0, 1), $urandom, 1'b0, RES_NONE);
            else if (pick < 90)
                issue_cmd(KIND_HIST, $urandom,
                          ($urandom_range(0, 3) != 0) ? $urandom_range(0, n + 1)
                                                      : $urandom_range(0, 127),
                          $urandom_range(0, 1), $urandom, 1'b0, RES_NONE);
            else if (pick < 95)
                // batch that cannot fit, or an empty one
                issue_cmd(KIND_BATCH, $urandom, $urandom_range(0, 127),
                          $urandom_range(0, 1),
                          ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(n + 1, 65535),
                          1'b0, RES_NONE);
            else
                // noise: any kind, any field
                issue_cmd($urandom_range(0, 7), $urandom, $urandom_range(0, 127),
                          $urandom_range(0, 1), $urandom_range(0, 65535), 1'b0, RES_NONE);
        end

        // drain, then allow a full scan for any stray beat
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("covered %0d working commands in %0d beats, %0d results checked",
                 n_items, n_beats, n_checked);
        $display("over %0d slots_in_use settings and %0d overlong runs, %0d mismatches",
                 n_cfg, n_long, n_err);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: circular_page_buffer_map_top.f
rtl/cpbm_pkg.sv
rtl/cpbm_ctrl.sv
rtl/cpbm_dpath.sv
rtl/circular_page_buffer_map_top.sv
bench/testbench.sv
